FILE: sv/srts_pkg.sv
// Shared types, constants and codes for the sorted record table search block.
`timescale 1ns / 1ps
package srts_pkg;

  localparam int CAPACITY   = 64;
  localparam int TEXT_CHARS = 8;
  localparam int YEAR_CHARS = 8;

  localparam int CHAR_W = 64;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] FLD_TITLE = 2'd0;
  localparam logic [1:0] FLD_NAME  = 2'd1;
  localparam logic [1:0] FLD_YEAR  = 2'd2;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_RECORD   = 2'd1;
  localparam logic [1:0] ST_FULL         = 2'd2;
  localparam logic [1:0] ST_BAD_YEAR_KEY = 2'd3;

  localparam logic REG_SORT_FIELD = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [CHAR_W-1:0] title_chars;
    logic [CHAR_W-1:0] name_chars;
    logic [CHAR_W-1:0] year_chars;
    logic [CHAR_W-1:0] search_key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] out_title;
    logic [CHAR_W-1:0] out_name;
    logic [CHAR_W-1:0] out_year;
    logic [CNT_W-1:0]  entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic [CHAR_W-1:0] title;
    logic [CHAR_W-1:0] name;
    logic [CHAR_W-1:0] year;
  } rec_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

FILE: sv/srts_norm.sv
// String normalizer: keeps up to NCHARS leading bytes before the first zero, checks for digits.
`timescale 1ns / 1ps
module srts_norm #(
  parameter int NCHARS = srts_pkg::TEXT_CHARS
) (
  input  logic [srts_pkg::CHAR_W-1:0] raw,
  output logic [srts_pkg::CHAR_W-1:0] norm,
  output logic                        digits
);

  always_comb begin
    logic       stop_v;
    logic       stop2_v;
    logic [7:0] b_v;
    norm    = '0;
    digits  = 1'b1;
    stop_v  = 1'b0;
    stop2_v = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b_v = raw[63-8*i -: 8];
      if (i < NCHARS && !stop_v) begin
        if (b_v == 8'h00) begin
          stop_v = 1'b1;
        end else begin
          norm[63-8*i -: 8] = b_v;
        end
      end else begin
        stop_v = 1'b1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      b_v = norm[63-8*i -: 8];
      if (!stop2_v) begin
        if (b_v == 8'h00) begin
          stop2_v = 1'b1;
        end else if (!(b_v inside {[8'h30:8'h39]})) begin
          digits = 1'b0;
        end
      end
    end
  end

endmodule

FILE: sv/srts_store.sv
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps
module srts_store #(
  parameter int DEPTH = srts_pkg::CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  srts_pkg::rec_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output srts_pkg::rec_t rdata
);

  srts_pkg::rec_t mem [DEPTH];
  srts_pkg::rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/srts_cmp.sv
// Shared key comparator: selects the key field of a stored record and compares.
`timescale 1ns / 1ps
module srts_cmp (
  input  logic [srts_pkg::CHAR_W-1:0] key,
  input  srts_pkg::rec_t              rec,
  input  logic [1:0]                  fld,
  output srts_pkg::cmp_t              res
);

  logic [srts_pkg::CHAR_W-1:0] probe;

  always_comb begin
    case (fld)
      srts_pkg::FLD_TITLE: probe = rec.title;
      srts_pkg::FLD_NAME:  probe = rec.name;
      default:             probe = rec.year;
    endcase
    res.lt = key < probe;
    res.eq = key == probe;
  end

endmodule

FILE: sv/sorted_record_table_search.sv
// Top level: sorted record table with insertion and binary-search lookup.
`timescale 1ns / 1ps
// The table keeps up to CAPACITY records in ascending order of the key field
// chosen by sort_field. Every step goes through one memory read port and one
// 64-bit comparator; each table entry touched is first read, then compared.
// An insert moves m records up one place, where m is at most the record count,
// and then writes the new record; a lookup makes p probes, with p at most
// floor(log2(count)) + 1; a rejected item goes straight to its result. The
// block takes a new request only when idle; a result waits in the output
// register, and the next result holds the block until that register is free.
module sorted_record_table_search #(
  parameter int CAPACITY   = srts_pkg::CAPACITY,
  parameter int TEXT_CHARS = srts_pkg::TEXT_CHARS,
  parameter int YEAR_CHARS = srts_pkg::YEAR_CHARS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  srts_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output srts_pkg::out_rsp_t          out_rsp,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [srts_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = srts_pkg::CHAR_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS_RD  = 6'b000010,
    S_INS_CMP = 6'b000100,
    S_LK_RD   = 6'b001000,
    S_LK_CMP  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         sort_field_r, sort_field_nxt;
  logic [1:0]         fld_r, fld_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      hi_r, hi_nxt;
  logic [W-1:0]       key_r, key_nxt;
  srts_pkg::rec_t     rec_r, rec_nxt;
  srts_pkg::out_rsp_t res_r, res_nxt;
  srts_pkg::out_rsp_t out_rsp_r, out_rsp_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [W-1:0]       t_norm, n_norm, y_norm, kt_norm, ky_norm;
  logic               t_dig, n_dig, y_dig, kt_dig, ky_dig;
  logic [1:0]         fld_cur;
  logic               in_acc;
  logic               cfg_wr;
  logic [CW-1:0]      mid_w;

  logic               st_we, st_re;
  logic [AW-1:0]      st_waddr, st_raddr;
  srts_pkg::rec_t     st_wdata, st_rdata;
  srts_pkg::cmp_t     cmp;

  srts_norm #(.NCHARS(TEXT_CHARS)) u_norm_title (
    .raw(in_req.title_chars), .norm(t_norm), .digits(t_dig));
  srts_norm #(.NCHARS(TEXT_CHARS)) u_norm_name (
    .raw(in_req.name_chars), .norm(n_norm), .digits(n_dig));
  srts_norm #(.NCHARS(YEAR_CHARS)) u_norm_year (
    .raw(in_req.year_chars), .norm(y_norm), .digits(y_dig));
  srts_norm #(.NCHARS(TEXT_CHARS)) u_norm_ktext (
    .raw(in_req.search_key), .norm(kt_norm), .digits(kt_dig));
  srts_norm #(.NCHARS(YEAR_CHARS)) u_norm_kyear (
    .raw(in_req.search_key), .norm(ky_norm), .digits(ky_dig));

  srts_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  srts_cmp u_cmp (
    .key (key_r),
    .rec (st_rdata),
    .fld (fld_r),
    .res (cmp)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_rsp    = out_rsp_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == srts_pkg::REG_SORT_FIELD) ?
                      {30'd0, sort_field_r} : 32'd0;
  assign fld_cur    = (sort_field_r == 2'd3) ? srts_pkg::FLD_YEAR : sort_field_r;
  assign mid_w      = lo_r + ((hi_r - CW'(1) - lo_r) >> 1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    sort_field_nxt = sort_field_r;
    fld_nxt        = fld_r;
    idx_nxt        = idx_r;
    mid_nxt        = mid_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    key_nxt        = key_r;
    rec_nxt        = rec_r;
    res_nxt        = res_r;
    out_rsp_nxt    = out_rsp_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    st_we          = 1'b0;
    st_waddr       = idx_r;
    st_wdata       = rec_r;
    st_re          = 1'b0;
    st_raddr       = idx_r - AW'(1);

    if (cfg_wr && cfg_paddr[2] == srts_pkg::REG_SORT_FIELD) begin
      sort_field_nxt = cfg_pwdata[1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rec_nxt = '{title: t_norm, name: n_norm, year: y_norm};
          fld_nxt = fld_cur;
          res_nxt = '{status: srts_pkg::ST_OK, found: 1'b0, position: '0,
                      out_title: '0, out_name: '0, out_year: '0,
                      entry_count: srts_pkg::CNT_W'(count_r)};
          if (in_req.opcode == srts_pkg::OP_INSERT) begin
            case (fld_cur)
              srts_pkg::FLD_TITLE: key_nxt = t_norm;
              srts_pkg::FLD_NAME:  key_nxt = n_norm;
              default:             key_nxt = y_norm;
            endcase
            idx_nxt = AW'(count_r);
            if (n_norm == '0 || y_norm == '0 || !y_dig) begin
              res_nxt.status = srts_pkg::ST_BAD_RECORD;
              state_nxt      = S_DONE;
            end else if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = srts_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            key_nxt = (fld_cur == srts_pkg::FLD_YEAR) ? ky_norm : kt_norm;
            lo_nxt  = '0;
            hi_nxt  = count_r;
            if (fld_cur == srts_pkg::FLD_YEAR && !ky_dig) begin
              res_nxt.status = srts_pkg::ST_BAD_YEAR_KEY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_LK_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          st_we     = 1'b1;
          count_nxt = count_r + CW'(1);
          res_nxt   = '{status: srts_pkg::ST_OK, found: 1'b0,
                        position: srts_pkg::POS_W'(idx_r),
                        out_title: rec_r.title, out_name: rec_r.name,
                        out_year: rec_r.year,
                        entry_count: srts_pkg::CNT_W'(count_r + CW'(1))};
          state_nxt = S_DONE;
        end else begin
          st_re     = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        st_we = 1'b1;
        if (cmp.lt) begin
          st_wdata  = st_rdata;
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          res_nxt   = '{status: srts_pkg::ST_OK, found: 1'b0,
                        position: srts_pkg::POS_W'(idx_r),
                        out_title: rec_r.title, out_name: rec_r.name,
                        out_year: rec_r.year,
                        entry_count: srts_pkg::CNT_W'(count_r + CW'(1))};
          state_nxt = S_DONE;
        end
      end
      S_LK_RD: begin
        if (lo_r < hi_r) begin
          st_re     = 1'b1;
          st_raddr  = AW'(mid_w);
          mid_nxt   = AW'(mid_w);
          state_nxt = S_LK_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LK_CMP: begin
        if (cmp.eq) begin
          res_nxt.found     = 1'b1;
          res_nxt.position  = srts_pkg::POS_W'(mid_r);
          res_nxt.out_title = st_rdata.title;
          res_nxt.out_name  = st_rdata.name;
          res_nxt.out_year  = st_rdata.year;
          state_nxt         = S_DONE;
        end else begin
          if (cmp.lt) begin
            hi_nxt = CW'(mid_r);
          end else begin
            lo_nxt = CW'(mid_r) + CW'(1);
          end
          state_nxt = S_LK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      sort_field_r <= srts_pkg::FLD_TITLE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      sort_field_r <= sort_field_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fld_r     <= fld_nxt;
    idx_r     <= idx_nxt;
    mid_r     <= mid_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    key_r     <= key_nxt;
    rec_r     <= rec_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  a_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == S_INS_RD || state_r == S_INS_CMP))
    else $error("table written outside an insert");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("record count changed by other than one");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_CMP) |-> (lo_r < hi_r && CW'(mid_r) >= lo_r && CW'(mid_r) < hi_r))
    else $error("probe outside search window");

endmodule

FILE: sim/tb_top.sv
// Testbench for the sorted record table: self-predicting checks of inserts and lookups.
`timescale 1ns / 1ps
module tb_top;
  import srts_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_req_t             in_req;
  logic                out_valid;
  logic                out_ready;
  out_rsp_t            out_rsp;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  logic [CHAR_W-1:0]   rec_title [CAPACITY];
  logic [CHAR_W-1:0]   rec_name  [CAPACITY];
  logic [CHAR_W-1:0]   rec_year  [CAPACITY];
  int                  rec_count;
  logic [1:0]          key_sel;
  out_rsp_t            pending_results [$];
  int                  mismatch_count;
  int                  hold_cycles;
  bit                  no_idle;

  sorted_record_table_search uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rsp    (out_rsp),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] trim_text(logic [CHAR_W-1:0] v, int nchars);
    logic [CHAR_W-1:0] r;
    bit                ended;
    int                i;
    r = '0;
    ended = 1'b0;
    for (i = 0; i < nchars && i < 8; i++) begin
      if (v[63-8*i -: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[63-8*i -: 8] = v[63-8*i -: 8];
    end
    return r;
  endfunction

  function automatic bit is_digits(logic [CHAR_W-1:0] v);
    logic [7:0] b;
    bit         ended;
    bit         ok;
    int         i;
    ended = 1'b0;
    ok = 1'b1;
    for (i = 0; i < 8; i++) begin
      b = v[63-8*i -: 8];
      if (b == 8'h00) ended = 1'b1;
      if (!ended && (b < "0" || b > "9")) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [CHAR_W-1:0] key_of(int idx, logic [1:0] fld);
    case (fld)
      FLD_TITLE: return rec_title[idx];
      FLD_NAME:  return rec_name[idx];
      default:   return rec_year[idx];
    endcase
  endfunction

  function automatic logic [1:0] active_field();
    return (key_sel > FLD_YEAR) ? FLD_YEAR : key_sel;
  endfunction

  function automatic out_rsp_t predict_table_step(in_req_t r);
    out_rsp_t          rsp;
    logic [1:0]        fld;
    logic [CHAR_W-1:0] t;
    logic [CHAR_W-1:0] n;
    logic [CHAR_W-1:0] y;
    logic [CHAR_W-1:0] k;
    logic [CHAR_W-1:0] probe;
    int                i;
    int                lo;
    int                hi;
    int                mid;
    bit                hit;
    rsp = '0;
    fld = active_field();
    if (r.opcode == OP_INSERT) begin
      t = trim_text(r.title_chars, TEXT_CHARS);
      n = trim_text(r.name_chars, TEXT_CHARS);
      y = trim_text(r.year_chars, YEAR_CHARS);
      if (n == '0 || y == '0 || !is_digits(y)) begin
        rsp.status = ST_BAD_RECORD;
      end else if (rec_count >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        k = (fld == FLD_TITLE) ? t : (fld == FLD_NAME) ? n : y;
        i = rec_count;
        while (i > 0 && k < key_of(i - 1, fld)) begin
          rec_title[i] = rec_title[i-1];
          rec_name[i]  = rec_name[i-1];
          rec_year[i]  = rec_year[i-1];
          i--;
        end
        rec_title[i] = t;
        rec_name[i]  = n;
        rec_year[i]  = y;
        rec_count++;
        rsp.status    = ST_OK;
        rsp.position  = POS_W'(i);
        rsp.out_title = t;
        rsp.out_name  = n;
        rsp.out_year  = y;
      end
    end else begin
      k = trim_text(r.search_key, (fld == FLD_YEAR) ? YEAR_CHARS : TEXT_CHARS);
      if (fld == FLD_YEAR && !is_digits(k)) begin
        rsp.status = ST_BAD_YEAR_KEY;
      end else begin
        rsp.status = ST_OK;
        lo = 0;
        hi = rec_count - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          probe = key_of(mid, fld);
          if (k == probe) begin
            hit = 1'b1;
            rsp.found     = 1'b1;
            rsp.position  = POS_W'(mid);
            rsp.out_title = rec_title[mid];
            rsp.out_name  = rec_name[mid];
            rsp.out_year  = rec_year[mid];
          end else if (k < probe) begin
            hi = mid - 1;
          end else begin
            lo = mid + 1;
          end
        end
      end
    end
    rsp.entry_count = CNT_W'(rec_count);
    return rsp;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CHAR_W-1:0] make_string(int len, bit narrow, bit digits);
    logic [CHAR_W-1:0] v;
    int                i;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) v = '0;
    for (i = 0; i < 8; i++) begin
      if (i < len) begin
        if (digits) v[63-8*i -: 8] = 8'("0" + $urandom_range(0, narrow ? 1 : 9));
        else if (narrow) v[63-8*i -: 8] = 8'("a" + $urandom_range(0, 2));
        else v[63-8*i -: 8] = 8'($urandom_range(1, 255));
      end else if (i == len) begin
        v[63-8*i -: 8] = 8'h00;
      end
    end
    return v;
  endfunction

  function automatic in_req_t make_good_record(bit narrow);
    in_req_t r;
    r.opcode      = OP_INSERT;
    r.title_chars = make_string($urandom_range(0, narrow ? 2 : 8), narrow, 1'b0);
    r.name_chars  = make_string($urandom_range(1, narrow ? 2 : 8), narrow, 1'b0);
    r.year_chars  = make_string($urandom_range(1, narrow ? 2 : 8), narrow, 1'b1);
    r.search_key  = {$urandom, $urandom};
    return r;
  endfunction

  function automatic in_req_t make_bad_record();
    in_req_t    r;
    logic [7:0] b;
    int         len;
    r = make_good_record($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: r.name_chars = make_string(0, 1'b0, 1'b0);
      1: r.year_chars = make_string(0, 1'b0, 1'b1);
      default: begin
        len = $urandom_range(1, 8);
        r.year_chars = make_string(len, 1'b0, 1'b1);
        do b = 8'($urandom_range(1, 255)); while (b >= "0" && b <= "9");
        r.year_chars[63-8*$urandom_range(0, len - 1) -: 8] = b;
      end
    endcase
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t    r;
    logic [1:0] fld;
    int         pick;
    bit         narrow;
    r.opcode      = 1'($urandom);
    r.title_chars = {$urandom, $urandom};
    r.name_chars  = {$urandom, $urandom};
    r.year_chars  = {$urandom, $urandom};
    r.search_key  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    narrow = $urandom_range(0, 1);
    fld = active_field();
    if (pick < 5) return r;
    if (pick < 40) return make_good_record(narrow);
    if (pick < 50) return make_bad_record();
    r.opcode = OP_LOOKUP;
    if (rec_count > 0 && $urandom_range(0, 99) < 70)
      r.search_key = key_of($urandom_range(0, rec_count - 1), fld);
    else if (fld == FLD_YEAR && $urandom_range(0, 3) != 0)
      r.search_key = make_string($urandom_range(0, 8), narrow, 1'b1);
    else
      r.search_key = make_string($urandom_range(0, 8), narrow, 1'b0);
    return r;
  endfunction

  function automatic in_req_t insert_req(logic [63:0] t, logic [63:0] n, logic [63:0] y);
    in_req_t r;
    r.opcode      = OP_INSERT;
    r.title_chars = t;
    r.name_chars  = n;
    r.year_chars  = y;
    r.search_key  = {$urandom, $urandom};
    return r;
  endfunction

  function automatic in_req_t lookup_req(logic [63:0] k);
    in_req_t r;
    r.opcode      = OP_LOOKUP;
    r.title_chars = {$urandom, $urandom};
    r.name_chars  = {$urandom, $urandom};
    r.year_chars  = {$urandom, $urandom};
    r.search_key  = k;
    return r;
  endfunction

  task automatic send_request(in_req_t r);
    int gap;
    gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   = r;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_table_step(r));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sort_field(logic [1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = ADDR_W'(4 * REG_SORT_FIELD);
    cfg_pwdata  = 32'(v);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    key_sel = v;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("tb_top: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_rsp.status), 64'(0));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(out_rsp.status), 64'(want.status));
        check_field("found", 64'(out_rsp.found), 64'(want.found));
        check_field("position", 64'(out_rsp.position), 64'(want.position));
        check_field("out_title", out_rsp.out_title, want.out_title);
        check_field("out_name", out_rsp.out_name, want.out_name);
        check_field("out_year", out_rsp.out_year, want.out_year);
        check_field("entry_count", 64'(out_rsp.entry_count), 64'(want.entry_count));
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  task automatic test_empty_lookups();
    send_request(lookup_req('1));
    send_request(lookup_req('0));
  endtask

  task automatic test_rejected_records();
    send_request(insert_req({"t", 56'h0}, 64'h00FF_FFFF_FFFF_FFFF, {"1999", 32'h0}));
    send_request(insert_req({"t", 56'h0}, {"n", 56'h0}, 64'h00FF_FFFF_FFFF_FFFF));
    send_request(insert_req({"t", 56'h0}, {"n", 56'h0}, {"19A", 40'h0}));
    send_request(insert_req({"t", 56'h0}, {"n", 56'h0}, {"/", 56'h0}));
    send_request(insert_req({"t", 56'h0}, {"n", 56'h0}, {":", 56'h0}));
  endtask

  task automatic test_field_extremes();
    send_request(insert_req('1, '1, "99999999"));
    send_request(insert_req('0, {"a", 56'h0}, {"0", 56'h0}));
    send_request(insert_req({"ab", 8'h0, "garba"}, {"ab", 48'h0}, {"1999", 8'h0, "xyz"}));
    send_request(lookup_req('1));
    send_request(lookup_req('0));
    send_request(lookup_req({"ab", 8'h0, "zzzzz"}));
  endtask

  task automatic test_key_fields();
    write_sort_field(FLD_NAME);
    send_request(lookup_req('1));
    write_sort_field(FLD_YEAR);
    send_request(lookup_req({"19a", 40'h0}));
    send_request(lookup_req({"1999", 8'h0, "xyz"}));
    write_sort_field(2'd3);
    send_request(lookup_req({"0", 56'h0}));
    send_request(insert_req({"z", 56'h0}, {"m", 56'h0}, {"2000", 32'h0}));
  endtask

  task automatic test_fill_to_full();
    int fld;
    for (fld = 0; fld < 4; fld++) begin
      write_sort_field(2'(fld));
      repeat (60) send_request(random_request());
    end
    while (rec_count < CAPACITY) send_request(make_good_record($urandom_range(0, 1)));
    send_request(make_good_record(1'b0));
    send_request(make_bad_record());
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 300;
    no_idle = 1'b1;
    repeat (12) send_request(random_request());
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int seg;
    for (seg = 0; seg < 6; seg++) begin
      write_sort_field((seg == 0) ? FLD_TITLE : (seg == 5) ? 2'd3 : 2'($urandom_range(0, 3)));
      no_idle = (seg == 2);
      repeat (280) send_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    rec_count      = 0;
    key_sel        = FLD_TITLE;
    mismatch_count = 0;
    hold_cycles    = 0;
    no_idle        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_lookups();
    test_rejected_records();
    test_field_extremes();
    test_key_fields();
    test_fill_to_full();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
